@@ design/median_motion_outlier_filter_defines.svh @@
// Assertion macros for the filter module.
`ifndef MEDIAN_MOTION_OUTLIER_FILTER_DEFINES_SVH
`define MEDIAN_MOTION_OUTLIER_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// A condition that must hold at every clock edge outside reset.
`define MMOF_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");
// A condition that must be followed by another one in the next cycle.
`define MMOF_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("sequence violated");
`else
`define MMOF_ASSERT_ALWAYS(label, expr)
`define MMOF_ASSERT_NEXT(label, cond, expr)
`endif
`endif

@@ design/mmof_pkg.sv @@
package mmof_pkg;

  localparam int MAX_PAIRS = 128;
  localparam int IDX_W     = 7;
  localparam int CNT_W     = 8;
  localparam int D_W       = 17;
  localparam int SQ_W      = 20;
  localparam int SLACK_W   = 12;
  localparam int CFG_W     = 20;

  localparam logic REG_MIN_MOTION_SQ = 1'b0;
  localparam logic REG_OUTLIER_SLACK = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic           keep;
    logic [D_W-1:0] dx;
    logic [D_W-1:0] dy;
  } entry_t;

  // True when 2|d-m| > |m| + 2*slack.
  function automatic logic off_axis(input logic [D_W-1:0] d, input logic [D_W-1:0] m,
                                    input logic [SLACK_W-1:0] slack);
    logic signed [D_W:0]   diff;
    logic [D_W:0]          adiff;
    logic [D_W-1:0]        am;
    logic [D_W+1:0]        lhs;
    logic [D_W+1:0]        rhs;
    diff  = $signed({d[D_W-1], d}) - $signed({m[D_W-1], m});
    adiff = diff[D_W] ? D_W'(0) - diff : diff;
    am    = m[D_W-1] ? D_W'(0) - m : m;
    lhs   = {adiff, 1'b0};
    rhs   = {2'b00, am} + {(D_W+2-SLACK_W-1)'(0), slack, 1'b0};
    return lhs > rhs;
  endfunction

endpackage

@@ design/median_motion_outlier_filter.sv @@
// Median motion outlier filter. A transfer is taken when start is high and busy is low.
// A load (cmd 0) stores one pair's motion and motion-test flag while the store has room.
// The final load then selects the upper-middle median of the surviving dx and dy values
// by counting, for each surviving candidate, the survivors below and at or below it: the
// candidate walk and the scan share the single read port of the pair store. A filter pass
// then rewrites the keep flag of each outlier; with no survivors both medians are zero and
// no pass runs. A read (cmd 1) shows its result on the result ports for exactly one cycle
// with strobe high, and the receiver cannot stall it. The pair store has no reset; a read
// of an index at or beyond the stored count reports keep low.
module median_motion_outlier_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [15:0]                   first_x,
  input  logic [15:0]                   first_y,
  input  logic [15:0]                   second_x,
  input  logic [15:0]                   second_y,
  input  logic                          tracked,
  input  logic                          final_pair,
  input  logic [mmof_pkg::IDX_W-1:0]    read_index,
  input  logic                          cfg_write,
  input  logic                          cfg_addr,
  input  logic [mmof_pkg::CFG_W-1:0]    cfg_data,
  output logic                          strobe,
  output logic [mmof_pkg::IDX_W-1:0]    pair_index,
  output logic                          keep,
  output logic signed [mmof_pkg::D_W-1:0] median_dx,
  output logic signed [mmof_pkg::D_W-1:0] median_dy
);
  import mmof_pkg::*;

  `include "median_motion_outlier_filter_defines.svh"

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_LOAD_MUL = 10'b0000000010,
    S_LOAD_SUM = 10'b0000000100,
    S_READ     = 10'b0000001000,
    S_SEL_CAND = 10'b0000010000,
    S_SEL_CWAIT = 10'b0000100000,
    S_SEL_SCAN = 10'b0001000000,
    S_SEL_EVAL = 10'b0010000000,
    S_FLT_RD   = 10'b0100000000,
    S_FLT_WR   = 10'b1000000000
  } state_t;

  state_t state;

  logic [SQ_W-1:0]    min_motion_sq;
  logic [SLACK_W-1:0] outlier_slack;

  logic [CNT_W-1:0] pair_count;
  logic [CNT_W-1:0] survivor_count;
  logic             set_closed;
  logic [D_W-1:0]   median_x_reg;
  logic [D_W-1:0]   median_y_reg;

  // Load pipeline registers.
  logic [D_W-1:0] ld_dx;
  logic [D_W-1:0] ld_dy;
  logic           ld_tracked;
  logic           ld_final;
  logic [31:0]    sq_x;
  logic [31:0]    sq_y;

  // Selection registers.
  logic [CNT_W-1:0] sel_i;
  logic [CNT_W-1:0] scan_j;
  logic             scan_pend;
  logic [D_W-1:0]   cand_x;
  logic [D_W-1:0]   cand_y;
  logic [CNT_W-1:0] lt_x, le_x, lt_y, le_y;
  logic             found_x, found_y;

  logic [IDX_W-1:0] rd_index;

  // Store ports.
  logic             st_we;
  logic [IDX_W-1:0] st_waddr;
  entry_t           st_wdata;
  logic [IDX_W-1:0] st_raddr;
  entry_t           st_rdata;

  mmof_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  logic accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Absolute motion values are below 2^16, so their squares fit in 32 bits.
  logic [D_W-1:0] abs_dx, abs_dy;
  assign abs_dx = ld_dx[D_W-1] ? D_W'(0) - ld_dx : ld_dx;
  assign abs_dy = ld_dy[D_W-1] ? D_W'(0) - ld_dy : ld_dy;

  logic [32:0]      mag;
  logic             ld_keep;
  logic             ld_room;
  logic [CNT_W-1:0] surv_next;
  assign mag       = {1'b0, sq_x} + {1'b0, sq_y};
  assign ld_keep   = ld_tracked && (mag >= {13'd0, min_motion_sq});
  assign ld_room   = (pair_count < CNT_W'(MAX_PAIRS));
  assign surv_next = survivor_count + CNT_W'(ld_room && ld_keep);

  // Rank test for the current candidate on each axis.
  logic [CNT_W-1:0] half_k;
  logic             hit_x, hit_y;
  logic             done_x, done_y;
  assign half_k = survivor_count >> 1;
  assign hit_x  = (lt_x <= half_k) && (half_k < le_x);
  assign hit_y  = (lt_y <= half_k) && (half_k < le_y);
  assign done_x = found_x || hit_x;
  assign done_y = found_y || hit_y;

  logic outlier;
  assign outlier = off_axis(st_rdata.dx, median_x_reg, outlier_slack) ||
                   off_axis(st_rdata.dy, median_y_reg, outlier_slack);

  always_comb begin
    st_we    = 1'b0;
    st_waddr = pair_count[IDX_W-1:0];
    st_wdata = '{keep: ld_keep, dx: ld_dx, dy: ld_dy};
    st_raddr = sel_i[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        st_raddr = read_index;
      end
      S_LOAD_SUM: begin
        st_we = ld_room;
      end
      S_SEL_SCAN: begin
        st_raddr = scan_j[IDX_W-1:0];
      end
      S_FLT_WR: begin
        st_we    = st_rdata.keep && outlier;
        st_waddr = sel_i[IDX_W-1:0];
        st_wdata = '{keep: 1'b0, dx: st_rdata.dx, dy: st_rdata.dy};
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_motion_sq <= SQ_W'(2304);
      outlier_slack <= SLACK_W'(16);
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_MIN_MOTION_SQ: min_motion_sq <= cfg_data[SQ_W-1:0];
        REG_OUTLIER_SLACK: outlier_slack <= cfg_data[SLACK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    sq_x <= abs_dx[15:0] * abs_dx[15:0];
    sq_y <= abs_dy[15:0] * abs_dy[15:0];
    if (accept) begin
      ld_dx      <= D_W'({1'b0, second_x}) - D_W'({1'b0, first_x});
      ld_dy      <= D_W'({1'b0, second_y}) - D_W'({1'b0, first_y});
      ld_tracked <= tracked;
      ld_final   <= final_pair;
      rd_index   <= read_index;
    end
    if (state == S_READ) begin
      pair_index <= rd_index;
      keep       <= st_rdata.keep && ({1'b0, rd_index} < pair_count);
      median_dx  <= median_x_reg;
      median_dy  <= median_y_reg;
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pair_count     <= '0;
      survivor_count <= '0;
      set_closed     <= 1'b0;
      median_x_reg   <= '0;
      median_y_reg   <= '0;
      strobe         <= 1'b0;
      sel_i          <= '0;
      scan_j         <= '0;
      scan_pend      <= 1'b0;
      found_x        <= 1'b0;
      found_y        <= 1'b0;
      lt_x           <= '0;
      le_x           <= '0;
      lt_y           <= '0;
      le_y           <= '0;
      cand_x         <= '0;
      cand_y         <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_READ) begin
              state <= S_READ;
            end else begin
              state <= S_LOAD_MUL;
              if (set_closed) begin
                pair_count     <= '0;
                survivor_count <= '0;
                set_closed     <= 1'b0;
              end
            end
          end
        end
        S_READ: begin
          strobe <= 1'b1;
          state  <= S_IDLE;
        end
        S_LOAD_MUL: begin
          state <= S_LOAD_SUM;
        end
        S_LOAD_SUM: begin
          pair_count     <= pair_count + CNT_W'(ld_room);
          survivor_count <= surv_next;
          sel_i          <= '0;
          found_x        <= 1'b0;
          found_y        <= 1'b0;
          if (!ld_final) begin
            state <= S_IDLE;
          end else if (surv_next == '0) begin
            // No survivors: both medians are zero and no flag can change.
            median_x_reg <= '0;
            median_y_reg <= '0;
            set_closed   <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_SEL_CAND;
          end
        end
        S_SEL_CAND: begin
          state <= S_SEL_CWAIT;
        end
        S_SEL_CWAIT: begin
          cand_x <= st_rdata.dx;
          cand_y <= st_rdata.dy;
          lt_x   <= '0;
          le_x   <= '0;
          lt_y   <= '0;
          le_y   <= '0;
          scan_j <= '0;
          scan_pend <= 1'b0;
          if (st_rdata.keep) begin
            state <= S_SEL_SCAN;
          end else begin
            sel_i <= sel_i + CNT_W'(1);
            state <= S_SEL_CAND;
          end
        end
        S_SEL_SCAN: begin
          if (scan_pend && st_rdata.keep) begin
            lt_x <= lt_x + CNT_W'($signed(st_rdata.dx) <  $signed(cand_x));
            le_x <= le_x + CNT_W'($signed(st_rdata.dx) <= $signed(cand_x));
            lt_y <= lt_y + CNT_W'($signed(st_rdata.dy) <  $signed(cand_y));
            le_y <= le_y + CNT_W'($signed(st_rdata.dy) <= $signed(cand_y));
          end
          if (scan_j < pair_count) begin
            scan_j    <= scan_j + CNT_W'(1);
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
            state     <= S_SEL_EVAL;
          end
        end
        S_SEL_EVAL: begin
          if (!found_x && hit_x) begin
            median_x_reg <= cand_x;
            found_x      <= 1'b1;
          end
          if (!found_y && hit_y) begin
            median_y_reg <= cand_y;
            found_y      <= 1'b1;
          end
          if ((done_x && done_y) || (sel_i + CNT_W'(1) >= pair_count)) begin
            sel_i <= '0;
            state <= S_FLT_RD;
          end else begin
            sel_i <= sel_i + CNT_W'(1);
            state <= S_SEL_CAND;
          end
        end
        S_FLT_RD: begin
          state <= S_FLT_WR;
        end
        S_FLT_WR: begin
          if (sel_i + CNT_W'(1) >= pair_count) begin
            set_closed <= 1'b1;
            state      <= S_IDLE;
          end else begin
            sel_i <= sel_i + CNT_W'(1);
            state <= S_FLT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A read transfer always yields exactly one strobe, registered in the S_READ state.
  `MMOF_ASSERT_NEXT(a_read_strobe, state == S_READ, strobe)
  `MMOF_ASSERT_NEXT(a_strobe_from_read, !(state == S_READ), !strobe)
  `MMOF_ASSERT_ALWAYS(a_count_bound, pair_count <= CNT_W'(MAX_PAIRS))
  `MMOF_ASSERT_ALWAYS(a_survivor_bound, survivor_count <= pair_count)

endmodule

@@ design/mmof_store.sv @@
module mmof_store (
  input  logic                  clk,
  input  logic                  we,
  input  logic [mmof_pkg::IDX_W-1:0] waddr,
  input  mmof_pkg::entry_t      wdata,
  input  logic [mmof_pkg::IDX_W-1:0] raddr,
  output mmof_pkg::entry_t      rdata
);
  import mmof_pkg::*;

  entry_t mem [MAX_PAIRS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/sv/median_motion_outlier_filter_tb.sv @@
module median_motion_outlier_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mmof_pkg::*;

  // One input transfer as the sender sees it.
  typedef struct {
    logic        cmd;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] sx;
    logic [15:0] sy;
    logic        trk;
    logic        fin;
    logic [6:0]  idx;
  } pair_cmd_t;

  // One result transfer that a read should produce.
  typedef struct {
    logic [IDX_W-1:0]      idx;
    logic                  keep;
    logic signed [D_W-1:0] mdx;
    logic signed [D_W-1:0] mdy;
  } pair_report_t;

  localparam int WATCHDOG_LIMIT = 120000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cmd = CMD_LOAD;
  logic [15:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic tracked = 1'b0, final_pair = 1'b0;
  logic [IDX_W-1:0] read_index = '0;
  logic cfg_write = 1'b0;
  logic cfg_addr = REG_MIN_MOTION_SQ;
  logic [CFG_W-1:0] cfg_data = '0;
  logic strobe;
  logic [IDX_W-1:0] pair_index;
  logic keep;
  logic signed [D_W-1:0] median_dx, median_dy;

  median_motion_outlier_filter u_top (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow of the filter: configuration, pair stores and the last medians.
  logic [SQ_W-1:0]       thr_sq;
  logic [SLACK_W-1:0]    slack;
  logic signed [D_W-1:0] dx_mem [MAX_PAIRS];
  logic signed [D_W-1:0] dy_mem [MAX_PAIRS];
  logic                  keep_mem [MAX_PAIRS];
  int                    n_pairs;
  int                    n_kept;
  logic signed [D_W-1:0] med_x, med_y;
  logic                  set_done;

  pair_report_t reports_due[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;

  function automatic logic signed [D_W-1:0] upper_median(input logic is_x);
    int lt, le;
    logic signed [D_W-1:0] vi, vj;
    for (int i = 0; i < n_pairs; i++) begin
      if (!keep_mem[i]) continue;
      vi = is_x ? dx_mem[i] : dy_mem[i];
      lt = 0;
      le = 0;
      for (int j = 0; j < n_pairs; j++) begin
        if (!keep_mem[j]) continue;
        vj = is_x ? dx_mem[j] : dy_mem[j];
        if (vj < vi) lt++;
        if (vj <= vi) le++;
      end
      if (lt <= n_kept / 2 && n_kept / 2 < le) return vi;
    end
    return '0;
  endfunction

  // Exact form of |d-m| > |m|/2 + slack.
  function automatic bit strays(input logic signed [D_W-1:0] d, input logic signed [D_W-1:0] m);
    longint diff, am;
    diff = longint'(d) - longint'(m);
    am = m < 0 ? -longint'(m) : longint'(m);
    if (diff < 0) diff = -diff;
    return 2 * diff > am + 2 * longint'(slack);
  endfunction

  // Applies one accepted transfer to the shadow and queues any report it causes.
  task automatic predict_transfer(input pair_cmd_t c);
    logic signed [D_W-1:0] dx, dy;
    longint mag;
    logic k;
    pair_report_t r;
    if (c.cmd == CMD_LOAD) begin
      if (set_done) begin
        n_pairs = 0;
        n_kept = 0;
        set_done = 1'b0;
      end
      if (n_pairs < MAX_PAIRS) begin
        dx = $signed({1'b0, c.sx}) - $signed({1'b0, c.fx});
        dy = $signed({1'b0, c.sy}) - $signed({1'b0, c.fy});
        mag = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
        k = c.trk && mag >= longint'(thr_sq);
        dx_mem[n_pairs] = dx;
        dy_mem[n_pairs] = dy;
        keep_mem[n_pairs] = k;
        if (k) n_kept++;
        n_pairs++;
      end
      // The final flag closes the set even when the store was full.
      if (c.fin) begin
        med_x = upper_median(1'b1);
        med_y = upper_median(1'b0);
        for (int i = 0; i < n_pairs; i++)
          if (keep_mem[i] && (strays(dx_mem[i], med_x) || strays(dy_mem[i], med_y)))
            keep_mem[i] = 1'b0;
        set_done = 1'b1;
      end
    end else begin
      r.idx = c.idx;
      r.keep = (int'(c.idx) < n_pairs) ? keep_mem[c.idx] : 1'b0;
      r.mdx = med_x;
      r.mdy = med_y;
      reports_due = {reports_due, r};
    end
  endtask

  // Sends one transfer. Start stays high afterwards, so back-to-back
  // transfers keep it asserted; a random gap lowers it first. Busy only
  // changes at rising edges, so its value at the falling edge tells whether
  // the next rising edge takes the transfer.
  task automatic send_item(input pair_cmd_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cmd = c.cmd;
    first_x = c.fx;
    first_y = c.fy;
    second_x = c.sx;
    second_y = c.sy;
    tracked = c.trk;
    final_pair = c.fin;
    read_index = c.idx;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_transfer(c);
    @(negedge clk);
  endtask

  // Waits until every report has come and the block has gone quiet.
  task automatic drain();
    start = 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [CFG_W-1:0] value);
    drain();
    cfg_write = 1'b1;
    cfg_addr = addr;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    if (addr == REG_MIN_MOTION_SQ) thr_sq = value[SQ_W-1:0];
    else slack = value[SLACK_W-1:0];
  endtask

  function automatic pair_cmd_t load_motion(input int dx, input int dy, input bit trk,
                                            input bit fin);
    pair_cmd_t c;
    c.cmd = CMD_LOAD;
    c.fx = 16'($urandom);
    c.fy = 16'($urandom);
    c.sx = 16'(int'(c.fx) + dx);
    c.sy = 16'(int'(c.fy) + dy);
    // Keep the difference exact: choose the first point so the second does not wrap.
    if (int'(c.fx) + dx < 0 || int'(c.fx) + dx > 65535) begin
      c.fx = dx < 0 ? 16'(-dx) : 16'h0;
      c.sx = 16'(int'(c.fx) + dx);
    end
    if (int'(c.fy) + dy < 0 || int'(c.fy) + dy > 65535) begin
      c.fy = dy < 0 ? 16'(-dy) : 16'h0;
      c.sy = 16'(int'(c.fy) + dy);
    end
    c.trk = trk;
    c.fin = fin;
    c.idx = 7'($urandom);
    return c;
  endfunction

  function automatic pair_cmd_t read_cmd(input int idx);
    pair_cmd_t c;
    c = load_motion(0, 0, 1'b0, 1'b0);
    c.cmd = CMD_READ;
    c.idx = 7'(idx);
    return c;
  endfunction

  // Coordinate extremes, an untracked pair, reads before the set is closed and
  // beyond its count, the outlier test with no slack, and a set with no survivors.
  task automatic test_directed();
    pair_cmd_t c;
    send_item(read_cmd(0));
    c = load_motion(0, 0, 1'b1, 1'b0);
    c.fx = 16'h0000; c.fy = 16'hFFFF; c.sx = 16'hFFFF; c.sy = 16'h0000;
    send_item(c);
    c.fx = 16'hFFFF; c.fy = 16'h0000; c.sx = 16'h0000; c.sy = 16'hFFFF;
    send_item(c);
    send_item(load_motion(40, 40, 1'b0, 1'b0));
    send_item(read_cmd(1));
    send_item(read_cmd(2));
    send_item(load_motion(48, 0, 1'b1, 1'b1));
    send_item(read_cmd(0));
    send_item(read_cmd(3));
    send_item(read_cmd(4));
    send_item(read_cmd(127));
    // Median 48 with no slack: 32 is 16 below it, inside the limit of 24.
    write_reg(REG_MIN_MOTION_SQ, '0);
    write_reg(REG_OUTLIER_SLACK, '0);
    send_item(load_motion(32, 0, 1'b1, 1'b0));
    send_item(load_motion(32, 0, 1'b1, 1'b0));
    send_item(load_motion(48, 0, 1'b1, 1'b0));
    send_item(load_motion(49, 0, 1'b1, 1'b1));
    for (int i = 0; i < 4; i++) send_item(read_cmd(i));
    // A set whose pairs are all untracked has no survivors and median zero.
    send_item(load_motion(100, -100, 1'b0, 1'b1));
    send_item(read_cmd(0));
  endtask

  // More loads than the store holds; the overflow load still closes the set.
  task automatic test_store_full();
    for (int i = 0; i < MAX_PAIRS + 3; i++)
      send_item(load_motion(int'($urandom_range(0, 200)) - 100,
                            int'($urandom_range(0, 200)) - 100, 1'b1,
                            i == MAX_PAIRS + 2));
    send_item(read_cmd(0));
    send_item(read_cmd(MAX_PAIRS - 1));
    // The sender holds off here until every report is back.
    drain();
  endtask

  // Register extremes, each with a small set checked against it.
  task automatic test_config_extremes();
    logic [CFG_W-1:0] thr_vals[3];
    logic [CFG_W-1:0] slack_vals[3];
    thr_vals = '{20'hFFFFF, 20'd0, 20'd2304};
    slack_vals = '{20'hFFF, 20'd0, 20'd16};
    for (int s = 0; s < 3; s++) begin
      write_reg(REG_MIN_MOTION_SQ, thr_vals[s]);
      write_reg(REG_OUTLIER_SLACK, slack_vals[s]);
      for (int i = 0; i < 5; i++)
        send_item(load_motion(int'($urandom_range(0, 4000)) - 2000,
                              int'($urandom_range(0, 4000)) - 2000, 1'b1, i == 4));
      for (int i = 0; i < 5; i++) send_item(read_cmd(i));
    end
  endtask

  // Clustered motion with a few outliers, broken sets and noise.
  task automatic test_random(input int idle_pct, input int n_items);
    int sent, n_loads, bx, by, spread;
    pair_cmd_t c;
    send_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) write_reg(REG_MIN_MOTION_SQ, CFG_W'($urandom_range(0, 20000)));
        else write_reg(REG_OUTLIER_SLACK, CFG_W'($urandom_range(0, 64)));
      end
      n_loads = $urandom_range(1, 14);
      bx = int'($urandom_range(0, 1200)) - 600;
      by = int'($urandom_range(0, 1200)) - 600;
      spread = $urandom_range(1, 40);
      for (int i = 0; i < n_loads; i++) begin
        if ($urandom_range(19) == 0) begin
          // Full-range noise so every coordinate bit toggles.
          c = load_motion(0, 0, $urandom_range(1), 1'b0);
          c.fx = 16'($urandom); c.fy = 16'($urandom);
          c.sx = 16'($urandom); c.sy = 16'($urandom);
        end else if ($urandom_range(9) == 0) begin
          c = load_motion(bx * 3 + 500, -by, 1'b1, 1'b0);
        end else begin
          c = load_motion(bx + int'($urandom_range(0, 2 * spread)) - spread,
                          by + int'($urandom_range(0, 2 * spread)) - spread,
                          $urandom_range(15) != 0, 1'b0);
        end
        // Usually the last load closes the set; sometimes the flag is missing.
        c.fin = (i == n_loads - 1) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
        send_item(c);
        if ($urandom_range(19) == 0) send_item(read_cmd($urandom_range(0, i)));
        sent++;
      end
      for (int i = 0; i < n_loads + 2; i++) begin
        send_item(read_cmd($urandom_range(3) == 0 ? $urandom_range(0, 127)
                                                  : $urandom_range(0, n_loads)));
        sent++;
      end
    end
  endtask

  // Compares each result with the oldest report due, and counts quiet cycles.
  always @(posedge clk) begin
    pair_report_t r;
    if (!rst) begin
      if ((start && !busy) || strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[median_motion_outlier_filter] ERROR");
        $finish;
      end
      if (strobe) begin
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: index %0d keep %0b", pair_index, keep);
        end else begin
          r = reports_due.pop_front();
          if (pair_index !== r.idx || keep !== r.keep ||
              median_dx !== r.mdx || median_dy !== r.mdy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp idx %0d keep %0b mdx %0d mdy %0d, got %0d %0b %0d %0d",
                       r.idx, r.keep, r.mdx, r.mdy, pair_index, keep, median_dx, median_dy);
          end
        end
      end
    end
  end

  initial begin
    thr_sq = 20'd2304;
    slack = 12'd16;
    n_pairs = 0;
    n_kept = 0;
    med_x = '0;
    med_y = '0;
    set_done = 1'b0;
    for (int i = 0; i < MAX_PAIRS; i++) begin
      dx_mem[i] = '0;
      dy_mem[i] = '0;
      keep_mem[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_store_full();
    test_config_extremes();
    write_reg(REG_MIN_MOTION_SQ, 20'd2304);
    write_reg(REG_OUTLIER_SLACK, 20'd16);
    test_random(33, 480);
    test_random(76, 480);
    test_random(0, 480);
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("[median_motion_outlier_filter] OK");
    end else begin
      $display("[median_motion_outlier_filter] ERROR");
    end
    $finish;
  end

endmodule

@@ median_motion_outlier_filter.f @@
+incdir+design
design/mmof_pkg.sv
design/mmof_store.sv
design/median_motion_outlier_filter.sv
tb/sv/median_motion_outlier_filter_tb.sv
